FILE: hdl/bdhe_pkg.sv
// button debouncer package: widths, entry layout, event and register codes
// used by the top level and its checker, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdhe_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int PTR_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int MASK_W      = 5;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 16;
    localparam int HOLD_W      = 15;
    localparam int MAX_EVENTS  = 3;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        EV_RELEASED = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_SHORT    = 2'd2,
        EV_LONG     = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_DEBOUNCE   = 2'd1,
        CFG_HOLD_SHORT = 2'd2,
        CFG_HOLD_LONG  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              stable;
        logic [HOLD_W-1:0] short_timer;
        logic [HOLD_W-1:0] long_timer;
    } t_entry;

endpackage

`default_nettype wire

FILE: hdl/button_debounce_hold_events_top.sv
// button debouncer with press, release and hold events
// per-button state lives in one synchronous memory; uses bdhe_pkg
//
// usage:
//   tick channel (i_in_valid / o_in_ready, i_pressed_mask): one request per tick,
//   only the button under the round-robin scan pointer is handled
//   event channel (o_out_valid / i_out_ready): 0 to 3 events per tick, in order
//   pressed or released, short hold, long hold; o_last_event marks the last one
//   config channel (i_cfg_valid / o_cfg_ready): always ready, write only while idle
// timing: a tick's state is read when it is accepted, updated in the update stage,
//   and its events are then held in the event register that drives the output
// throughput: one tick per cycle while ticks make at most one event and the receiver
//   is ready; a tick making several events holds the event register until all are
//   taken, which stalls the next tick. the single event register sets this limit
// reset: scan pointer and entry valid bits cleared, registers to their
//   defaults, no events pending; entries not yet written read as zero
// stall: a stalled event register holds its events and the update stage,
//   which then holds o_in_ready low until room frees up
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_hold_events_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire [bdhe_pkg::MASK_W-1:0] i_pressed_mask,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic [bdhe_pkg::IDX_W-1:0] o_button_index,
    output logic [1:0]                o_event_code,
    output logic                      o_last_event,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire [1:0]                 i_cfg_index,
    input  wire [15:0]                i_cfg_data
);
    import bdhe_pkg::*;

    // configuration
    logic              r_enable;
    logic [CNT_W-1:0]  r_debounce;
    logic [HOLD_W-1:0] r_hold_short;
    logic [HOLD_W-1:0] r_hold_long;

    // scan pointer and update stage
    t_ptr r_ptr;
    t_ptr n_ptr;
    logic r_s1_valid;
    t_ptr r_s1_btn;
    logic r_s1_down;

    // state memory and forwarding
    t_entry r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_entry_valid;
    t_entry r_rd_data;
    t_entry r_fwd_data;
    logic   r_fwd;
    logic   r_hit;

    // event register
    logic [1:0]       r_b_cnt;
    logic [1:0]       r_b_code [MAX_EVENTS];
    logic [IDX_W-1:0] r_b_btn;

    logic in_acc;
    logic rd_en;
    logic s1_fire;
    logic out_acc;
    logic down;
    logic [NUM_BUTTONS-1:0] mask_ext;
    t_entry cur;
    t_entry upd;
    logic   ev_edge;
    logic [1:0] edge_code;
    logic   ev_short;
    logic   ev_long;
    logic [1:0] n_cnt;
    logic [1:0] n_code [MAX_EVENTS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_debounce   <= CNT_W'(20);
            r_hold_short <= HOLD_W'(500);
            r_hold_long  <= HOLD_W'(2000);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[CNT_W-1:0];
                CFG_HOLD_SHORT: r_hold_short <= i_cfg_data[HOLD_W-1:0];
                CFG_HOLD_LONG:  r_hold_long  <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_acc    = o_out_valid && i_out_ready;
    assign s1_fire    = r_s1_valid && ((r_b_cnt == 2'd0) || ((r_b_cnt == 2'd1) && i_out_ready));
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_acc     = i_in_valid && o_in_ready;
    assign rd_en      = in_acc && r_enable;

    assign mask_ext = NUM_BUTTONS'(i_pressed_mask);
    assign n_ptr    = (32'(r_ptr) + 32'd1 >= NUM_BUTTONS) ? '0 : t_ptr'(32'(r_ptr) + 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_ptr <= n_ptr;
            end
            if (rd_en) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_btn  <= r_ptr;
            r_s1_down <= mask_ext[r_ptr];
        end
    end

    // state memory, registered read
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_mem[r_s1_btn] <= upd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (s1_fire) begin
            r_entry_valid[r_s1_btn] <= 1'b1;
        end
    end

    // write in flight to the entry being read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_fwd      <= s1_fire && (r_s1_btn == r_ptr);
            r_fwd_data <= upd;
            r_hit      <= r_entry_valid[r_ptr];
        end
    end

    assign down = r_s1_down;

    always_comb begin
        if (r_fwd) begin
            cur = r_fwd_data;
        end else if (r_hit) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
    end

    // read-modify-write of the visited entry
    always_comb begin
        upd       = cur;
        ev_edge   = 1'b0;
        edge_code = EV_RELEASED;
        ev_short  = 1'b0;
        ev_long   = 1'b0;
        if (!down) begin
            if (cur.count != '0) begin
                upd.count = cur.count - CNT_W'(1);
                if ((upd.count == '0) && cur.stable) begin
                    ev_edge         = 1'b1;
                    edge_code       = EV_RELEASED;
                    upd.stable      = 1'b0;
                    upd.short_timer = '0;
                    upd.long_timer  = '0;
                end
            end
        end else begin
            if (cur.count < r_debounce) begin
                upd.count = cur.count + CNT_W'(1);
                if (upd.count >= r_debounce) begin
                    ev_edge         = 1'b1;
                    edge_code       = EV_PRESSED;
                    upd.stable      = 1'b1;
                    upd.short_timer = r_hold_short;
                    upd.long_timer  = r_hold_long;
                end
            end
        end
        if (upd.short_timer != '0) begin
            upd.short_timer = upd.short_timer - HOLD_W'(1);
            ev_short        = (upd.short_timer == '0);
        end
        if (upd.long_timer != '0) begin
            upd.long_timer = upd.long_timer - HOLD_W'(1);
            ev_long        = (upd.long_timer == '0);
        end
    end

    // pack events in order
    always_comb begin
        n_cnt     = 2'd0;
        n_code[0] = EV_RELEASED;
        n_code[1] = EV_RELEASED;
        n_code[2] = EV_RELEASED;
        if (ev_edge) begin
            n_code[n_cnt] = edge_code;
            n_cnt         = n_cnt + 2'd1;
        end
        if (ev_short) begin
            n_code[n_cnt] = EV_SHORT;
            n_cnt         = n_cnt + 2'd1;
        end
        if (ev_long) begin
            n_code[n_cnt] = EV_LONG;
            n_cnt         = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_cnt <= 2'd0;
        end else if (s1_fire) begin
            r_b_cnt <= n_cnt;
        end else if (out_acc) begin
            r_b_cnt <= r_b_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_b_btn     <= IDX_W'(r_s1_btn);
            r_b_code[0] <= n_code[0];
            r_b_code[1] <= n_code[1];
            r_b_code[2] <= n_code[2];
        end else if (out_acc) begin
            r_b_code[0] <= r_b_code[1];
            r_b_code[1] <= r_b_code[2];
        end
    end

    assign o_out_valid    = (r_b_cnt != 2'd0);
    assign o_button_index = r_b_btn;
    assign o_event_code   = r_b_code[0];
    assign o_last_event   = (r_b_cnt == 2'd1);

endmodule

`default_nettype wire

FILE: hdl/bdhe_chk.sv
// port-level checker for the button debouncer top level, bound to it
// uses bdhe_pkg event codes
`timescale 1ns / 1ps
`default_nettype none

module bdhe_chk (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire [bdhe_pkg::IDX_W-1:0]  o_button_index,
    input wire [1:0]                  o_event_code,
    input wire                        o_last_event
);
    import bdhe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_button_index)
            && $stable(o_event_code) && $stable(o_last_event))
        else $error("stalled event changed");

    a_same_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_event |=>
            o_out_valid && (o_button_index == $past(o_button_index)))
        else $error("events of one tick split or changed button");

    a_event_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_event |=> o_event_code > $past(o_event_code))
        else $error("events of one tick out of order");

    a_long_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_code == EV_LONG) |-> o_last_event)
        else $error("long hold not the last event");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("event pending after reset");

endmodule

bind button_debounce_hold_events_top bdhe_chk u_bdhe_chk (.*);

`default_nettype wire

FILE: sim/button_debounce_hold_events_top_test.sv
// self-checking test of the button debouncer with press, release and hold events
// directed and random tick traffic against an event predictor; uses bdhe_pkg
`timescale 1ns / 1ps

module button_debounce_hold_events_top_test;

    import bdhe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_event           code;
        logic             last;
    } t_button_event;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [MASK_W-1:0]   i_pressed_mask = '0;
    logic                i_out_ready    = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic [1:0]          i_cfg_index    = '0;
    logic [15:0]         i_cfg_data     = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [IDX_W-1:0]    o_button_index;
    logic [1:0]          o_event_code;
    logic                o_last_event;
    logic                o_cfg_ready;

    // predictor state and register copy
    logic                cfg_enable;
    logic [CNT_W-1:0]    cfg_debounce;
    logic [HOLD_W-1:0]   cfg_hold_short;
    logic [HOLD_W-1:0]   cfg_hold_long;
    t_ptr                scan_ptr;
    logic [CNT_W-1:0]    deb_count [NUM_BUTTONS];
    logic                stable_down [NUM_BUTTONS];
    logic [HOLD_W-1:0]   short_timer [NUM_BUTTONS];
    logic [HOLD_W-1:0]   long_timer [NUM_BUTTONS];

    t_button_event       pending_events [$];
    t_button_event       head_event;
    int                  mismatch_count    = 0;
    int                  cycle_count       = 0;
    int                  sender_idle_pct   = 0;
    int                  receiver_idle_pct = 0;

    button_debounce_hold_events_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pressed_mask (i_pressed_mask),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_button_index (o_button_index),
        .o_event_code   (o_event_code),
        .o_last_event   (o_last_event),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        mismatch_count++;
    endtask

    // event checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("event with none pending, code", int'(o_event_code), -1);
            end else begin
                head_event = pending_events.pop_front();
                if (o_button_index !== head_event.idx)
                    report_mismatch("button_index", int'(o_button_index), int'(head_event.idx));
                if (o_event_code !== head_event.code)
                    report_mismatch("event_code", int'(o_event_code), int'(head_event.code));
                if (o_last_event !== head_event.last)
                    report_mismatch("last_event", int'(o_last_event), int'(head_event.last));
            end
        end
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    function automatic void reset_debouncer();
        cfg_enable     = 1'b1;
        cfg_debounce   = 16'd20;
        cfg_hold_short = 15'd500;
        cfg_hold_long  = 15'd2000;
        scan_ptr       = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            deb_count[b]   = '0;
            stable_down[b] = 1'b0;
            short_timer[b] = '0;
            long_timer[b]  = '0;
        end
    endfunction

    function automatic void advance_debouncer(input logic [MASK_W-1:0] mask);
        t_event        codes [MAX_EVENTS];
        int            n;
        int            b;
        t_button_event ev;
        n = 0;
        if (!cfg_enable)
            return;
        if (scan_ptr >= NUM_BUTTONS)
            scan_ptr = '0;
        b = int'(scan_ptr);
        if (!mask[b]) begin
            if (deb_count[b] > 0) begin
                deb_count[b] = deb_count[b] - CNT_W'(1);
                if (deb_count[b] == 0 && stable_down[b]) begin
                    codes[n] = EV_RELEASED;
                    n++;
                    stable_down[b] = 1'b0;
                    short_timer[b] = '0;
                    long_timer[b]  = '0;
                end
            end
        end else if (deb_count[b] < cfg_debounce) begin
            deb_count[b] = deb_count[b] + CNT_W'(1);
            if (deb_count[b] >= cfg_debounce) begin
                codes[n] = EV_PRESSED;
                n++;
                stable_down[b] = 1'b1;
                short_timer[b] = cfg_hold_short;
                long_timer[b]  = cfg_hold_long;
            end
        end
        if (short_timer[b] > 0) begin
            short_timer[b] = short_timer[b] - HOLD_W'(1);
            if (short_timer[b] == 0) begin
                codes[n] = EV_SHORT;
                n++;
            end
        end
        if (long_timer[b] > 0) begin
            long_timer[b] = long_timer[b] - HOLD_W'(1);
            if (long_timer[b] == 0) begin
                codes[n] = EV_LONG;
                n++;
            end
        end
        scan_ptr = (b + 1 >= NUM_BUTTONS) ? t_ptr'(0) : t_ptr'(b + 1);
        for (int k = 0; k < n; k++) begin
            ev.idx  = IDX_W'(b);
            ev.code = codes[k];
            ev.last = (k == n - 1);
            pending_events.push_back(ev);
        end
    endfunction

    // one tick request; valid stays high after acceptance until the next call decides
    task automatic send_tick(input logic [MASK_W-1:0] mask);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pressed_mask <= mask;
        do @(posedge i_clk); while (!o_in_ready);
        advance_debouncer(mask);
    endtask

    task automatic send_ticks(input logic [MASK_W-1:0] mask, input int count);
        for (int i = 0; i < count; i++)
            send_tick(mask);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic en, input logic [15:0] debounce,
                                input logic [15:0] hold_short, input logic [15:0] hold_long);
        t_cfg_reg    reg_order [4];
        logic [15:0] values [4];
        reg_order[0] = CFG_ENABLE;
        reg_order[1] = CFG_DEBOUNCE;
        reg_order[2] = CFG_HOLD_SHORT;
        reg_order[3] = CFG_HOLD_LONG;
        values[0]    = {15'd0, en};
        values[1]    = debounce;
        values[2]    = hold_short;
        values[3]    = hold_long;
        i_cfg_valid <= 1'b1;
        for (int r = 0; r < 4; r++) begin
            i_cfg_index <= reg_order[r];
            i_cfg_data  <= values[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (reg_order[r])
                CFG_ENABLE:     cfg_enable     = values[r][0];
                CFG_DEBOUNCE:   cfg_debounce   = values[r];
                CFG_HOLD_SHORT: cfg_hold_short = values[r][HOLD_W-1:0];
                CFG_HOLD_LONG:  cfg_hold_long  = values[r][HOLD_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // defaults after reset: threshold 20 is far away
    task automatic test_reset_defaults();
        send_ticks(5'h1F, 5);
        wait_idle();
    endtask

    // counter at threshold, then back to zero without an accepted press
    task automatic test_release_before_accept();
        write_config(1'b1, 16'd1, 16'd1, 16'd1);
        send_ticks(5'h00, 5);
        wait_idle();
    endtask

    // press, short and long hold in one tick, then releases
    task automatic test_triple_events();
        send_ticks(5'h1F, 5);
        send_ticks(5'h00, 5);
        wait_idle();
    endtask

    task automatic test_extreme_settings();
        write_config(1'b1, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_ticks(5'h15, 3);
        send_ticks(5'h0A, 2);
        wait_idle();
    endtask

    task automatic test_zero_threshold();
        write_config(1'b1, 16'd0, 16'd0, 16'd5);
        send_ticks(5'h1F, 2);
        send_ticks(5'h00, 2);
        wait_idle();
    endtask

    task automatic test_disabled();
        write_config(1'b0, 16'd1, 16'd1, 16'd1);
        send_ticks(5'h1F, 2);
        send_ticks(5'h00, 1);
        send_ticks(5'h1F, 1);
        wait_idle();
    endtask

    // held levels change now and then, with bounce noise on top
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        logic [MASK_W-1:0] held;
        logic [MASK_W-1:0] mask;
        int                run_left;
        logic [15:0]       hold_short;
        logic [15:0]       hold_long;
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        held              = MASK_W'($urandom);
        for (int phase = 0; phase < 3; phase++) begin
            hold_short = (phase == 1) ? 16'd0 : 16'($urandom_range(1, 12));
            hold_long  = (phase == 2) ? 16'd0 : 16'($urandom_range(1, 25));
            write_config(1'b1, 16'($urandom_range(1, 4)), hold_short, hold_long);
            run_left = 0;
            for (int i = 0; i < 40; i++) begin
                if (run_left == 0) begin
                    if ($urandom_range(3) == 0)
                        held = MASK_W'($urandom);
                    else
                        held = held ^ (MASK_W'(1) << $urandom_range(MASK_W - 1));
                    run_left = $urandom_range(5, 30);
                end
                run_left--;
                mask = held;
                if ($urandom_range(99) < 15)
                    mask = mask ^ MASK_W'($urandom_range(1, 31));
                send_tick(mask);
            end
            wait_idle();
        end
    endtask

    initial begin
        reset_debouncer();
        sender_idle_pct   = 23;
        receiver_idle_pct = 46;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_release_before_accept();
        test_triple_events();
        test_extreme_settings();
        test_zero_threshold();
        test_disabled();
        test_random_traffic(23, 46);
        test_random_traffic(46, 23);
        test_random_traffic(0, 0);
        wait_idle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
